// ----- rtl/jesl_pkg.sv -----
// Shared types, constants and helper functions for the JPEG EXIF segment locator.
package jesl_pkg;

    localparam int CFG_WIDTH      = 19;
    localparam int STATUS_WIDTH   = 2;
    localparam int OFFSET_WIDTH   = 18;
    localparam int LENGTH_WIDTH   = 16;
    localparam int DEF_POS_BITS   = 19;
    localparam int WINDOW_LIMIT   = 256 * 1024;
    localparam int PREFIX_LEN     = 6;
    localparam int MIN_HEAD_BYTES = 4;

    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] CODE_SOI    = 8'hD8;
    localparam logic [7:0] CODE_EOI    = 8'hD9;
    localparam logic [7:0] CODE_SOS    = 8'hDA;
    localparam logic [7:0] CODE_APP1   = 8'hE1;

    localparam logic [15:0] SEG_LEN_MIN  = 16'd2;
    localparam logic [15:0] APP1_LEN_MIN = 16'd8;

    localparam logic [STATUS_WIDTH-1:0] ST_EXIF_FOUND = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_NOT_JPEG   = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_NO_EXIF    = 2'd2;

    typedef enum logic [3:0] {
        PH_SOI0,
        PH_SOI1,
        PH_MARK,
        PH_CODE,
        PH_LENHI,
        PH_LENLO,
        PH_SKIP,
        PH_PREFIX,
        PH_WAIT,
        PH_STOP,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic                    emit;
        logic [STATUS_WIDTH-1:0] status;
        logic [OFFSET_WIDTH-1:0] offset;
        logic [LENGTH_WIDTH-1:0] length;
    } t_result;

    // "Exif" followed by two zero bytes
    function automatic logic [7:0] exif_sig(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h45;
            3'd1:    b = 8'h78;
            3'd2:    b = 8'h69;
            3'd3:    b = 8'h66;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/jesl_ifs.sv -----
// Handshake channel interfaces for the byte stream, the result and the window register.
interface jesl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface jesl_result_if
    import jesl_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [STATUS_WIDTH-1:0] status;
    logic [OFFSET_WIDTH-1:0] payload_offset;
    logic [LENGTH_WIDTH-1:0] payload_length;

    modport source (output valid, output status, output payload_offset,
                    output payload_length, input ready);
    modport sink   (input valid, input status, input payload_offset,
                    input payload_length, output ready);
endinterface

interface jesl_cfg_if
    import jesl_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/jpeg_exif_segment_locator.sv -----
// Top level: walks JPEG marker segments and reports where the EXIF TIFF payload sits.
//
// Usage:
//   i_byte carries the file one word per handshake (data_byte, last). Only the
//   first scan_window bytes are examined; last ends the file and rearms the
//   block for the next one.
//   o_result carries exactly one word per file: status 0 with the TIFF payload
//   offset and length, or status 1 (not a JPEG) / 2 (no EXIF segment).
//   i_cfg writes scan_window; write it only while no file is in flight.
// Throughput: one byte per cycle while o_result does not stall, set by the
//   combinational segment walker between the state registers and the result register.
// Output: the result word is registered and appears on o_result in the cycle
//   after the byte that decides it is accepted.
// Reset: the walker waits for the first byte of a file; scan_window returns to
//   262144 and the result register is emptied.
// Stall: a held result keeps i_byte.ready low only while the result register
//   is full and o_result.ready is low; otherwise bytes keep flowing.
module jpeg_exif_segment_locator
    import jesl_pkg::*;
#(
    parameter int POSITION_BITS = DEF_POS_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    jesl_cfg_if.sink     i_cfg,
    jesl_byte_if.sink    i_byte,
    jesl_result_if.source o_result
);

    localparam int PB       = POSITION_BITS;
    localparam int SEG_BITS = PB + 1;
    localparam longint POS_MAX = (64'd1 << PB) - 64'd1;
    localparam longint WIN_MAX_INT = (WINDOW_LIMIT < POS_MAX) ? WINDOW_LIMIT : POS_MAX;
    localparam logic [PB-1:0]        WIN_MAX     = PB'(WIN_MAX_INT);
    localparam logic [CFG_WIDTH-1:0] WIN_MAX_CFG = CFG_WIDTH'(WIN_MAX_INT);
    localparam logic [PB-1:0]        HEAD_MIN    = PB'(MIN_HEAD_BYTES);

    // Clamped window, stored at write time
    logic [PB-1:0]       r_window;

    // Walker state
    t_phase              r_phase,         n_phase;
    logic [PB-1:0]       r_position,      n_position;
    logic [SEG_BITS-1:0] r_segment_end,   n_segment_end;
    logic [7:0]          r_marker_code,   n_marker_code;
    logic [7:0]          r_length_high,   n_length_high;
    logic [2:0]          r_prefix_matched, n_prefix_matched;
    logic [PB-1:0]       r_payload_start, n_payload_start;

    // Result register
    logic                    r_out_valid;
    logic [STATUS_WIDTH-1:0] r_status;
    logic [OFFSET_WIDTH-1:0] r_offset;
    logic [LENGTH_WIDTH-1:0] r_length;

    logic    accept;
    logic    active;
    t_result proc_res;
    t_result res;

    assign i_cfg.ready  = 1'b1;
    assign i_byte.ready = !r_out_valid || o_result.ready;
    assign accept       = i_byte.valid && i_byte.ready;
    // A byte is processed while no word was reported and the head is not used up
    assign active       = (r_phase != PH_DONE) && (r_position < r_window);

    // Next state: one step of the segment walk
    always_comb begin
        logic [PB-1:0]       nxt;
        logic [15:0]         seg_len;
        logic [SEG_BITS-1:0] seg_end_new;
        logic [2:0]          pm_next;

        nxt         = r_position + PB'(1);
        seg_len     = {r_length_high, i_byte.data_byte};
        seg_end_new = SEG_BITS'(r_position) + SEG_BITS'(seg_len) - SEG_BITS'(1);
        pm_next     = r_prefix_matched + 3'd1;

        n_phase          = r_phase;
        n_position       = r_position;
        n_segment_end    = r_segment_end;
        n_marker_code    = r_marker_code;
        n_length_high    = r_length_high;
        n_prefix_matched = r_prefix_matched;
        n_payload_start  = r_payload_start;
        proc_res         = '0;

        if (active) begin
            n_position = nxt;
            case (r_phase)
                PH_SOI0: begin
                    if (i_byte.data_byte != MARK_PREFIX) begin
                        proc_res.emit   = 1'b1;
                        proc_res.status = ST_NOT_JPEG;
                    end else begin
                        n_phase = PH_SOI1;
                    end
                end
                PH_SOI1: begin
                    if (i_byte.data_byte != CODE_SOI) begin
                        proc_res.emit   = 1'b1;
                        proc_res.status = ST_NOT_JPEG;
                    end else begin
                        n_segment_end = SEG_BITS'(2);
                        n_phase       = PH_MARK;
                    end
                end
                PH_MARK: begin
                    n_phase = (i_byte.data_byte == MARK_PREFIX) ? PH_CODE : PH_STOP;
                end
                PH_CODE: begin
                    n_marker_code = i_byte.data_byte;
                    n_phase = (i_byte.data_byte == CODE_EOI || i_byte.data_byte == CODE_SOS)
                              ? PH_STOP : PH_LENHI;
                end
                PH_LENHI: begin
                    n_length_high = i_byte.data_byte;
                    n_phase       = PH_LENLO;
                end
                PH_LENLO: begin
                    if (seg_len < SEG_LEN_MIN) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_segment_end = seg_end_new;
                        if (r_marker_code == CODE_APP1 && seg_len >= APP1_LEN_MIN) begin
                            n_prefix_matched = 3'd0;
                            n_phase          = PH_PREFIX;
                        end else begin
                            n_phase = (SEG_BITS'(nxt) == seg_end_new) ? PH_MARK : PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (SEG_BITS'(nxt) == r_segment_end) begin
                        n_phase = PH_MARK;
                    end
                end
                PH_PREFIX: begin
                    if (r_prefix_matched >= 3'(PREFIX_LEN) ||
                        i_byte.data_byte != exif_sig(r_prefix_matched)) begin
                        n_phase = (SEG_BITS'(nxt) == r_segment_end) ? PH_MARK : PH_SKIP;
                    end else begin
                        n_prefix_matched = pm_next;
                        if (pm_next == 3'(PREFIX_LEN)) begin
                            n_payload_start = nxt;
                            if (SEG_BITS'(nxt) == r_segment_end) begin
                                proc_res.emit   = 1'b1;
                                proc_res.status = ST_EXIF_FOUND;
                                proc_res.offset = OFFSET_WIDTH'(nxt);
                            end else begin
                                n_phase = PH_WAIT;
                            end
                        end
                    end
                end
                PH_WAIT: begin
                    if (SEG_BITS'(nxt) == r_segment_end) begin
                        proc_res.emit   = 1'b1;
                        proc_res.status = ST_EXIF_FOUND;
                        proc_res.offset = OFFSET_WIDTH'(r_payload_start);
                        proc_res.length = LENGTH_WIDTH'(nxt - r_payload_start);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Outputs: pick the one word this byte produces, if any
    always_comb begin
        res = '0;
        if (accept && r_phase != PH_DONE) begin
            if (proc_res.emit) begin
                res = proc_res;
            end else if (n_phase == PH_STOP && n_position >= HEAD_MIN) begin
                res.emit   = 1'b1;
                res.status = ST_NO_EXIF;
            end else if (n_position >= r_window || i_byte.last) begin
                res.emit   = 1'b1;
                res.status = (n_position < HEAD_MIN) ? ST_NOT_JPEG : ST_NO_EXIF;
            end
        end
    end

    // Window register: clamp to WINDOW_LIMIT or the largest head the position counter covers, whichever is smaller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WIN_MAX;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_window <= (i_cfg.data > WIN_MAX_CFG) ? WIN_MAX : PB'(i_cfg.data);
        end
    end

    // Walker state: advance on every accepted byte, rearm after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_SOI0;
            r_position       <= '0;
            r_segment_end    <= '0;
            r_marker_code    <= '0;
            r_length_high    <= '0;
            r_prefix_matched <= '0;
            r_payload_start  <= '0;
        end else if (accept) begin
            if (i_byte.last) begin
                r_phase          <= PH_SOI0;
                r_position       <= '0;
                r_segment_end    <= '0;
                r_marker_code    <= '0;
                r_length_high    <= '0;
                r_prefix_matched <= '0;
                r_payload_start  <= '0;
            end else begin
                r_phase          <= res.emit ? PH_DONE : n_phase;
                r_position       <= n_position;
                r_segment_end    <= n_segment_end;
                r_marker_code    <= n_marker_code;
                r_length_high    <= n_length_high;
                r_prefix_matched <= n_prefix_matched;
                r_payload_start  <= n_payload_start;
            end
        end
    end

    // Result register: load on a reported word, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && res.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res.emit) begin
            r_status <= res.status;
            r_offset <= res.offset;
            r_length <= res.length;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.status         = r_status;
    assign o_result.payload_offset = r_offset;
    assign o_result.payload_length = r_length;

endmodule
